// ----- hdl/jgc_pkg.sv -----
`timescale 1ns / 1ps

package jgc_pkg;

	// Every glyph is sixteen rows high; the row index is the low nibble of a store address.
	localparam int GLYPH_ROWS = 16;
	localparam int ROW_W      = 4;

	// Transaction kinds.
	localparam logic [1:0] KIND_WR_HANGUL  = 2'd0;
	localparam logic [1:0] KIND_WR_SPECIAL = 2'd1;
	localparam logic [1:0] KIND_WR_ENGLISH = 2'd2;
	localparam logic [1:0] KIND_RENDER     = 2'd3;

	// Half-width selection.
	localparam logic [1:0] HALF_LEFT  = 2'd1;
	localparam logic [1:0] HALF_RIGHT = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_HANGUL  = 2'd0;
	localparam logic [1:0] ST_SPECIAL = 2'd1;
	localparam logic [1:0] ST_ENGLISH = 2'd2;
	localparam logic [1:0] ST_BLANK   = 2'd3;

	// Code space boundaries.
	localparam logic [7:0] SPEC_LEAD_LO = 8'hD9;
	localparam logic [7:0] SPEC_LEAD_HI = 8'hDE;
	localparam logic [7:0] HANJA_LEAD   = 8'hE0;
	localparam logic [7:0] TAIL_A_LO    = 8'h31;
	localparam logic [7:0] TAIL_A_HI    = 8'h7E;
	localparam logic [7:0] TAIL_B_LO    = 8'h91;
	localparam logic [7:0] TAIL_B_HI    = 8'hFE;
	localparam int         SPEC_ROW_SPAN = 'h5e * 2;
	localparam int         TAIL_B_OFFSET = 'h7f - 'h31;

	// Hangul glyph set layout in the store.
	localparam int INIT_SET_SIZE = 20;
	localparam int MED_SET_BASE  = 160;
	localparam int MED_SET_SIZE  = 22;
	localparam int FIN_SET_BASE  = 248;
	localparam int FIN_SET_SIZE  = 28;

	localparam logic [4:0] INIT_OF_CODE [32] = '{
		5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
		5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
	localparam logic [4:0] MED_OF_CODE [32] = '{
		5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd0, 5'd0, 5'd6, 5'd7,
		5'd8, 5'd9, 5'd10, 5'd11, 5'd0, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
		5'd0, 5'd0, 5'd18, 5'd19, 5'd20, 5'd21, 5'd0, 5'd0};
	localparam logic [4:0] FIN_OF_CODE [32] = '{
		5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
		5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd0, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
		5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0};

	// Initial-consonant set by medial, without and with a final.
	localparam logic [2:0] INIT_SET_OPEN [22] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
		3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0};
	localparam logic [2:0] INIT_SET_CLOSED [22] = '{
		3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7,
		3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5};
	// Medial set by initial, without and with a final.
	localparam logic [1:0] MED_SET_OPEN [20] = '{
		2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1};
	localparam logic [1:0] MED_SET_CLOSED [20] = '{
		2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
		2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3};
	// Final set by medial.
	localparam logic [1:0] FIN_SET_BY_MED [22] = '{
		2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
		2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1};

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] char_code;
		logic [1:0]  half_mode;
		logic [14:0] write_address;
		logic [15:0] write_data;
	} item_t;

	typedef struct packed {
		logic [3:0] row_number;
		logic [7:0] left_byte;
		logic [7:0] right_byte;
		logic [1:0] status;
		logic       last_row;
	} result_t;

endpackage

// ----- hdl/jgc_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module jgc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/johab_glyph_composer_core.sv -----
`timescale 1ns / 1ps

// Johab 16x16 glyph composer.
//
// The item channel (item_valid, item_ready, item) carries two sorts of transaction. A store
// write fills one word of the Hangul part, special symbol or English font store and
// produces no result. A render transaction turns a 16-bit character code into
// sixteen result transactions on the result channel (result_valid, result_ready, result),
// one per glyph row, top row first, with last_row set on the sixteenth.
//
// Rendering runs on a small sequencer around the font stores, which have one read port each.
// A row is read one part glyph at a time: the read state issues the first part's read and
// each accumulate step takes in one part, so a Hangul code, being the OR of up to three part
// glyphs, takes three part reads a row; special, English and unsupported codes take one.
// The block takes no new transaction while a render is under way.
//
// A single output register sits on the result channel. When the receiver stalls, the
// sequencer parks the finished row and waits; nothing is dropped or repeated.
// Reset empties the output register and returns the sequencer to idle; the font stores
// are not cleared and must be written before use.
module johab_glyph_composer_core #(
	parameter int HANGUL_GLYPHS  = 360,
	parameter int SPECIAL_GLYPHS = 1128,
	parameter int ENGLISH_GLYPHS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  jgc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output jgc_pkg::result_t result
);

	localparam int HAN_DEPTH  = HANGUL_GLYPHS * jgc_pkg::GLYPH_ROWS;
	localparam int SPEC_DEPTH = SPECIAL_GLYPHS * jgc_pkg::GLYPH_ROWS;
	localparam int ENG_DEPTH  = ENGLISH_GLYPHS * jgc_pkg::GLYPH_ROWS;
	localparam int HAW = $clog2(HAN_DEPTH);
	localparam int SAW = $clog2(SPEC_DEPTH);
	localparam int EAW = $clog2(ENG_DEPTH);

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_ACC  = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Render context captured when the transaction is taken.
	logic [1:0]  status_q;
	logic [1:0]  half_q;
	logic [8:0]  g1_q, g2_q, g3_q;
	logic [10:0] sglyph_q;
	logic [7:0]  eglyph_q;

	logic [3:0]  row_q;
	logic [1:0]  part_q;
	logic [15:0] acc_q;

	logic             res_valid_q;
	jgc_pkg::result_t res_q;

	// ------------------------------------------------------------------
	// Code decoding for a render transaction.
	// ------------------------------------------------------------------
	logic [7:0]  lead, tail;
	logic [4:0]  fi, mi, li;
	logic        closed;
	logic [2:0]  init_set;
	logic [1:0]  med_set, fin_set;
	logic [8:0]  g1_d, g2_d, g3_d;
	logic [2:0]  spec_row;
	logic [10:0] sglyph_d;
	logic [1:0]  status_d;

	always_comb begin
		lead     = item.char_code[15:8];
		tail     = item.char_code[7:0];
		fi       = jgc_pkg::INIT_OF_CODE[item.char_code[14:10]];
		mi       = jgc_pkg::MED_OF_CODE[item.char_code[9:5]];
		li       = jgc_pkg::FIN_OF_CODE[item.char_code[4:0]];
		closed   = (li != 5'd0);
		init_set = closed ? jgc_pkg::INIT_SET_CLOSED[mi] : jgc_pkg::INIT_SET_OPEN[mi];
		med_set  = closed ? jgc_pkg::MED_SET_CLOSED[fi] : jgc_pkg::MED_SET_OPEN[fi];
		fin_set  = jgc_pkg::FIN_SET_BY_MED[mi];
		g1_d = 9'(init_set) * 9'(jgc_pkg::INIT_SET_SIZE) + 9'(fi);
		g2_d = 9'(jgc_pkg::MED_SET_BASE) + 9'(med_set) * 9'(jgc_pkg::MED_SET_SIZE) + 9'(mi);
		g3_d = closed ? 9'(jgc_pkg::FIN_SET_BASE) + 9'(fin_set) * 9'(jgc_pkg::FIN_SET_SIZE)
			+ 9'(li) : 9'd0;

		// The lead byte picks a band of the special font, the tail a glyph within it.
		spec_row = 3'(lead - jgc_pkg::SPEC_LEAD_LO);
		sglyph_d = 11'(spec_row) * 11'(jgc_pkg::SPEC_ROW_SPAN);
		if (tail >= jgc_pkg::TAIL_B_LO) begin
			sglyph_d = sglyph_d + 11'(tail - jgc_pkg::TAIL_B_LO)
				+ 11'(jgc_pkg::TAIL_B_OFFSET);
		end else begin
			sglyph_d = sglyph_d + 11'(tail - jgc_pkg::TAIL_A_LO);
		end

		priority if (!item.char_code[15]) begin
			status_d = ({1'b0, tail} < 9'(ENGLISH_GLYPHS)) ? jgc_pkg::ST_ENGLISH
				: jgc_pkg::ST_BLANK;
		end else if (lead >= jgc_pkg::SPEC_LEAD_LO && lead <= jgc_pkg::SPEC_LEAD_HI) begin
			if (((tail >= jgc_pkg::TAIL_A_LO && tail <= jgc_pkg::TAIL_A_HI) ||
				(tail >= jgc_pkg::TAIL_B_LO && tail <= jgc_pkg::TAIL_B_HI)) &&
				({1'b0, sglyph_d} < 12'(SPECIAL_GLYPHS))) begin
				status_d = jgc_pkg::ST_SPECIAL;
			end else begin
				status_d = jgc_pkg::ST_BLANK;
			end
		end else if (lead >= jgc_pkg::HANJA_LEAD) begin
			// Hanja is not held in any store.
			status_d = jgc_pkg::ST_BLANK;
		end else begin
			status_d = jgc_pkg::ST_HANGUL;
		end
	end

	// ------------------------------------------------------------------
	// Handshake and store writes.
	// ------------------------------------------------------------------
	logic item_take;
	logic render_take;
	logic han_we, spec_we, eng_we;

	assign item_ready  = state_q[0];
	assign item_take   = item_valid && item_ready;
	assign render_take = item_take && (item.kind == jgc_pkg::KIND_RENDER);

	// Writes at or beyond the end of a store are dropped.
	assign han_we  = item_take && (item.kind == jgc_pkg::KIND_WR_HANGUL) &&
		({1'b0, item.write_address} < 16'(HAN_DEPTH));
	assign spec_we = item_take && (item.kind == jgc_pkg::KIND_WR_SPECIAL) &&
		({1'b0, item.write_address} < 16'(SPEC_DEPTH));
	assign eng_we  = item_take && (item.kind == jgc_pkg::KIND_WR_ENGLISH) &&
		({1'b0, item.write_address} < 16'(ENG_DEPTH));

	// ------------------------------------------------------------------
	// Read issue: one part glyph row per cycle from the stores, paused while a finished row waits in S_PUSH.
	// ------------------------------------------------------------------
	logic        last_part;
	logic        rd_en;
	logic [1:0]  rd_part;
	logic [8:0]  hsel;
	logic [15:0] han_rdata, spec_rdata;
	logic [7:0]  eng_rdata;

	assign last_part = (status_q == jgc_pkg::ST_HANGUL) ? (part_q == 2'd2) : (part_q == 2'd0);
	assign rd_en     = (state_q == S_READ) || ((state_q == S_ACC) && !last_part);
	assign rd_part   = (state_q == S_READ) ? 2'd0 : part_q + 2'd1;

	always_comb begin
		unique case (rd_part)
			2'd0:    hsel = g1_q;
			2'd1:    hsel = g2_q;
			default: hsel = g3_q;
		endcase
	end

	jgc_ram #(.WIDTH(16), .DEPTH(HAN_DEPTH)) u_han_ram (
		.clk   (clk),
		.we    (han_we),
		.waddr (HAW'(item.write_address)),
		.wdata (item.write_data),
		.re    (rd_en),
		.raddr (HAW'({hsel, row_q})),
		.rdata (han_rdata)
	);

	jgc_ram #(.WIDTH(16), .DEPTH(SPEC_DEPTH)) u_spec_ram (
		.clk   (clk),
		.we    (spec_we),
		.waddr (SAW'(item.write_address)),
		.wdata (item.write_data),
		.re    (rd_en),
		.raddr (SAW'({sglyph_q, row_q})),
		.rdata (spec_rdata)
	);

	jgc_ram #(.WIDTH(8), .DEPTH(ENG_DEPTH)) u_eng_ram (
		.clk   (clk),
		.we    (eng_we),
		.waddr (EAW'(item.write_address)),
		.wdata (item.write_data[7:0]),
		.re    (rd_en),
		.raddr (EAW'({eglyph_q, row_q})),
		.rdata (eng_rdata)
	);

	// ------------------------------------------------------------------
	// Accumulation of part rows and row composition.
	// ------------------------------------------------------------------
	logic [15:0]      rd_word, acc_word, push_word;
	logic             slot_free, push_en, last_row_now;
	jgc_pkg::result_t row_res;

	always_comb begin
		unique case (status_q)
			jgc_pkg::ST_HANGUL:  rd_word = han_rdata;
			jgc_pkg::ST_SPECIAL: rd_word = spec_rdata;
			jgc_pkg::ST_ENGLISH: rd_word = {8'd0, eng_rdata};
			default:             rd_word = 16'd0;
		endcase
	end

	// The first part of a row starts a fresh word; later parts are ORed in.
	assign acc_word     = ((part_q == 2'd0) ? 16'd0 : acc_q) | rd_word;
	assign push_word    = (state_q == S_ACC) ? acc_word : acc_q;
	assign slot_free    = !res_valid_q || result_ready;
	assign push_en      = (((state_q == S_ACC) && last_part) || (state_q == S_PUSH)) &&
		slot_free;
	assign last_row_now = (row_q == 4'(jgc_pkg::GLYPH_ROWS - 1));

	always_comb begin
		row_res.row_number = row_q;
		row_res.status     = status_q;
		row_res.last_row   = last_row_now;
		row_res.left_byte  = push_word[7:0];
		row_res.right_byte = push_word[15:8];
		// Half modes apply to the two-byte fonts only; English is already left aligned.
		if (status_q != jgc_pkg::ST_ENGLISH) begin
			if (half_q == jgc_pkg::HALF_LEFT) begin
				row_res.right_byte = 8'd0;
			end else if (half_q == jgc_pkg::HALF_RIGHT) begin
				row_res.left_byte = 8'd0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (render_take) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_ACC;
			end
			S_ACC, S_PUSH: begin
				if (push_en) begin
					state_d = last_row_now ? S_IDLE : S_READ;
				end else if ((state_q == S_ACC) && last_part) begin
					state_d = S_PUSH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			part_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (render_take) begin
				row_q  <= '0;
				part_q <= '0;
			end else if (push_en) begin
				row_q  <= row_q + 4'd1;
				part_q <= '0;
			end else if ((state_q == S_ACC) && !last_part) begin
				part_q <= part_q + 2'd1;
			end
			if (push_en) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (render_take) begin
			status_q <= status_d;
			half_q   <= item.half_mode;
			g1_q     <= g1_d;
			g2_q     <= g2_d;
			g3_q     <= g3_d;
			sglyph_q <= sglyph_d;
			eglyph_q <= item.char_code[7:0];
		end
		if (state_q == S_ACC) begin
			acc_q <= acc_word;
		end
		if (push_en) begin
			res_q <= row_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_render_starts: assert property (@(posedge clk) disable iff (!arst_n)
		render_take |=> (state_q == S_READ))
		else $error("render transaction did not start a row read");

	a_last_row_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && last_row_now) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after the last row");

	a_single_part: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ACC) && (status_q != jgc_pkg::ST_HANGUL)) |-> (part_q == 2'd0))
		else $error("more than one part read for a single-glyph code");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> (!res_valid_q || result_ready))
		else $error("output register overwritten while the receiver stalls");

endmodule
